// ===== design/cprt_pkg.sv =====
// Shared types and constants of the per-client connection rate table.
// Used by cprt_front, cprt_engine and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cprt_pkg;

	localparam int TABLE_ENTRIES_DEF  = 16;
	localparam int LOCAL_SESSIONS_DEF = 64;

	localparam int KEY_W     = 32;
	localparam int SESS_W    = 6;
	localparam int KIND_W    = 3;
	localparam int CNT_W     = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [KIND_W-1:0] KIND_CONNECT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DISCONNECT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SESS_END   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PURGE_DELAY   = 1'd1;

	localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd60;
	localparam logic [CFG_W-1:0] PURGE_DELAY_RST   = 16'd600;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_CONNECT,
		OP_DISCONNECT,
		OP_LOOKUP,
		OP_DUMP,
		OP_SESS_END,
		OP_TICK,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SESS_W-1:0] sess;
		logic              sess_ok;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fq_stat_t;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] conn_count;
		logic [CNT_W-1:0] conn_rate;
		logic [KEY_W-1:0] entry_key;
		logic             entry_present;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

// ===== design/per_client_connection_rate_table_core.sv =====
// Top level of the per-client connection rate table: configuration registers,
// front queue and table engine. Depends on cprt_pkg, cprt_front and cprt_engine.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to TABLE_ENTRIES client keys, each with an open
// connection count, a connection rate over a fixed window of sample_period
// ticks, and an idle mark used to purge entries whose count fell to zero.
// Request words enter a two-deep queue, so the input side keeps accepting
// until it is full, while the engine works and while a result word waits on
// the output. The engine handles one word at a time and writes at most one
// table record per cycle. A lookup, a disconnect of an unknown key and a
// connect that releases nothing pass through match, execute and emit steps;
// a disconnect of a known key and a connect that also releases the key its
// session held before add a drop step. A session end emits nothing and adds
// the drop step only when it releases a held key. A dump emits a header word,
// then walks every table slot. Any word that emits a result takes longer
// while the consumer stalls. A tick advances the time and, when it deletes
// entries, checks every local session to clear any that still held them.
// Results come out of a single output register; status 1 marks a lookup miss,
// a full table or an unknown request code. Configuration writes are always
// accepted and should only be issued while the block is idle.
module per_client_connection_rate_table_core #(
	parameter int TABLE_ENTRIES  = cprt_pkg::TABLE_ENTRIES_DEF,
	parameter int LOCAL_SESSIONS = cprt_pkg::LOCAL_SESSIONS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [cprt_pkg::KIND_W-1:0]    kind,
	input  wire  [cprt_pkg::KEY_W-1:0]     client_key,
	input  wire  [cprt_pkg::SESS_W-1:0]    local_session,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           status,
	output logic [cprt_pkg::CNT_W-1:0]     conn_count,
	output logic [cprt_pkg::CNT_W-1:0]     conn_rate,
	output logic [cprt_pkg::KEY_W-1:0]     entry_key,
	output logic                           entry_present,
	output logic                           last,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [cprt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [cprt_pkg::CFG_W-1:0]     cfg_data
);
	import cprt_pkg::*;

	logic [CFG_W-1:0] sample_period_q;
	logic [CFG_W-1:0] purge_delay_q;
	item_t            item;
	logic             item_valid;
	logic             item_ready;
	fq_stat_t         fq_stat;
	res_t             res;

	// Configuration has no side effects beyond the register itself, so the
	// port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= SAMPLE_PERIOD_RST;
			purge_delay_q   <= PURGE_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
				REG_PURGE_DELAY:   purge_delay_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cprt_front #(
		.LOCAL_SESSIONS(LOCAL_SESSIONS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.client_key   (client_key),
		.local_session(local_session),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.fq_stat      (fq_stat)
	);

	cprt_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.LOCAL_SESSIONS(LOCAL_SESSIONS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.sample_period(sample_period_q),
		.purge_delay  (purge_delay_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res          (res)
	);

	// The result word is carried as one struct and split onto the ports here.
	assign status        = res.status;
	assign conn_count    = res.conn_count;
	assign conn_rate     = res.conn_rate;
	assign entry_key     = res.entry_key;
	assign entry_present = res.entry_present;
	assign last          = res.last;

`ifndef NO_ASSERTIONS
	// A word taken in always leaves the queue non-empty at the next edge.
	a_accept_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !fq_stat.empty)
		else $error("queue empty right after an accepted word");

	// A full queue must hold off the input side.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		fq_stat.full |-> !in_ready)
		else $error("input ready while the queue is full");

	// The engine only takes a word that the queue actually holds.
	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready && fq_stat.empty |-> !item_valid)
		else $error("queue offers a word while empty");
`endif

endmodule

`default_nettype wire

// ===== design/cprt_front.sv =====
// Front end: decodes incoming words and buffers them in a two-deep queue.
// Depends on cprt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cprt_front #(
	parameter int LOCAL_SESSIONS = cprt_pkg::LOCAL_SESSIONS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [cprt_pkg::KIND_W-1:0] kind,
	input  wire  [cprt_pkg::KEY_W-1:0]  client_key,
	input  wire  [cprt_pkg::SESS_W-1:0] local_session,
	output logic                        item_valid,
	input  wire                         item_ready,
	output cprt_pkg::item_t             item,
	output cprt_pkg::fq_stat_t          fq_stat
);
	import cprt_pkg::*;

	item_t       q_mem [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	item_t       dec;
	logic        push;
	logic        pop;

	always_comb begin
		dec.key     = client_key;
		dec.sess    = local_session;
		dec.sess_ok = (9'(local_session) < 9'(LOCAL_SESSIONS));
		unique case (kind)
			KIND_CONNECT:    dec.op = OP_CONNECT;
			KIND_DISCONNECT: dec.op = OP_DISCONNECT;
			KIND_LOOKUP:     dec.op = OP_LOOKUP;
			KIND_DUMP:       dec.op = OP_DUMP;
			KIND_SESS_END:   dec.op = OP_SESS_END;
			KIND_TICK:       dec.op = OP_TICK;
			default:         dec.op = OP_BAD;
		endcase
	end

	assign in_ready      = (cnt_q != 2'd2);
	assign item_valid    = (cnt_q != 2'd0);
	assign item          = q_mem[rp_q];
	assign push          = in_valid && in_ready;
	assign pop           = item_valid && item_ready;
	assign fq_stat.empty = (cnt_q == 2'd0);
	assign fq_stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/cprt_engine.sv =====
// Back end: sequencer that searches and updates the client table, keeps the
// session holds in a memory and drives the registered result word. Depends on cprt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cprt_engine #(
	parameter int TABLE_ENTRIES  = cprt_pkg::TABLE_ENTRIES_DEF,
	parameter int LOCAL_SESSIONS = cprt_pkg::LOCAL_SESSIONS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        item_valid,
	output logic                       item_ready,
	input  cprt_pkg::item_t            item,
	input  wire  [cprt_pkg::CFG_W-1:0] sample_period,
	input  wire  [cprt_pkg::CFG_W-1:0] purge_delay,
	output logic                       out_valid,
	input  wire                        out_ready,
	output cprt_pkg::res_t             res
);
	import cprt_pkg::*;

	localparam int EW = $clog2(TABLE_ENTRIES);
	localparam int SW = (LOCAL_SESSIONS > 1) ? $clog2(LOCAL_SESSIONS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_MATCH, S_EXEC, S_DROP, S_EMIT, S_EMIT_CODE,
		S_DUMP_HDR, S_DUMP, S_SWP_RD, S_SWP_CHK
	} state_t;

	typedef enum logic [1:0] {AFT_ENTRY, AFT_ZERO, AFT_NONE} after_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  cnt;
		logic [CNT_W-1:0]  rate;
		logic [TIME_W-1:0] ws;
		logic [TIME_W-1:0] idle;
	} ent_t;

	state_t                   state_q;
	after_t                   after_q;
	item_t                    item_q;
	logic [EW-1:0]            rd_q;
	logic [EW-1:0]            tgt_q;
	logic [EW-1:0]            free_idx_q;
	logic                     hit_q;
	logic                     free_q;
	logic                     fail_q;
	logic [TIME_W-1:0]        now_q;
	logic [TABLE_ENTRIES-1:0] ent_vld_q;
	logic [TABLE_ENTRIES-1:0] del_q;
	logic [LOCAL_SESSIONS-1:0] sess_vld_q;
	logic [SW-1:0]            swp_q;
	logic                     out_vld_q;
	res_t                     out_q;

	ent_t                     ent_q [TABLE_ENTRIES];
	logic [EW-1:0]            sess_mem [LOCAL_SESSIONS];
	logic [EW-1:0]            sess_rd_q;

	ent_t                     rd_rec;
	logic                     hit_c;
	logic                     free_c;
	logic [EW-1:0]            hit_idx_c;
	logic [EW-1:0]            free_idx_c;
	logic [TABLE_ENTRIES-1:0] del_c;
	logic [TIME_W-1:0]        now_inc;
	logic                     above_c;
	logic [SW-1:0]            sidx;
	logic [SW-1:0]            m_raddr;
	logic                     m_we;
	logic [EW-1:0]            conn_idx;
	logic                     held_ok;
	logic                     out_free;
	logic                     out_load;
	logic                     e_we;
	logic [EW-1:0]            e_widx;
	ent_t                     e_wrec;

	assign rd_rec     = ent_q[rd_q];
	assign sidx       = SW'(item_q.sess);
	assign now_inc    = now_q + 32'd1;
	assign conn_idx   = hit_q ? rd_q : free_idx_q;
	assign held_ok    = sess_vld_q[sidx] && ent_vld_q[sess_rd_q];
	assign out_free   = !out_vld_q || out_ready;
	assign item_ready = (state_q == S_IDLE);
	assign out_valid  = out_vld_q;
	assign res        = out_q;
	assign m_raddr    = (state_q == S_MATCH) ? sidx : swp_q;
	assign m_we       = (state_q == S_EXEC) && (item_q.op == OP_CONNECT) &&
	                    item_q.sess_ok && (hit_q || free_q);

	// A new result word is loaded whenever an emitting state finds room.
	assign out_load   = out_free && ((state_q == S_EMIT) || (state_q == S_EMIT_CODE) ||
	                    (state_q == S_DUMP_HDR) || ((state_q == S_DUMP) && ent_vld_q[rd_q]));

	// Key search and lowest free slot, registered before use.
	always_comb begin
		hit_c      = 1'b0;
		free_c     = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (ent_vld_q[i] && (ent_q[i].key == item_q.key)) begin
				hit_c     = 1'b1;
				hit_idx_c = EW'(i);
			end
			if (!ent_vld_q[i]) begin
				free_c     = 1'b1;
				free_idx_c = EW'(i);
			end
		end
	end

	// Entries that expire on this tick, judged against the advanced time.
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			del_c[i] = ent_vld_q[i] && (ent_q[i].cnt == '0) &&
			           ((now_inc - ent_q[i].idle) >= 32'(purge_delay));
		end
	end

	always_comb begin
		above_c = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (EW'(i) > rd_q) begin
				above_c = above_c | ent_vld_q[i];
			end
		end
	end

	// Single write port of the entry table.
	always_comb begin
		e_we   = 1'b0;
		e_widx = rd_q;
		e_wrec = rd_rec;
		unique case (state_q)
			S_EXEC: begin
				if (item_q.op == OP_CONNECT) begin
					if (hit_q) begin
						e_we = 1'b1;
						if ((now_q - rd_rec.ws) > 32'(sample_period)) begin
							e_wrec.rate = 16'd1;
							e_wrec.ws   = now_q;
						end else if (rd_rec.rate != CNT_MAX) begin
							e_wrec.rate = rd_rec.rate + 16'd1;
						end
						if (rd_rec.cnt != CNT_MAX) begin
							e_wrec.cnt = rd_rec.cnt + 16'd1;
						end
					end else if (free_q) begin
						e_we   = 1'b1;
						e_widx = free_idx_q;
						e_wrec = '{item_q.key, 16'd1, 16'd1, now_q, 32'd0};
					end
				end
			end
			S_DROP: begin
				if (rd_rec.cnt != '0) begin
					e_we       = 1'b1;
					e_wrec.cnt = rd_rec.cnt - 16'd1;
					if (rd_rec.cnt == 16'd1) begin
						e_wrec.idle = now_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			ent_q[e_widx] <= e_wrec;
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			sess_mem[sidx] <= conn_idx;
		end
		sess_rd_q <= sess_mem[m_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			after_q    <= AFT_NONE;
			item_q     <= '0;
			rd_q       <= '0;
			tgt_q      <= '0;
			free_idx_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			fail_q     <= 1'b0;
			now_q      <= '0;
			ent_vld_q  <= '0;
			del_q      <= '0;
			sess_vld_q <= '0;
			swp_q      <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			out_vld_q <= out_load || (out_vld_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q  <= item;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					hit_q      <= hit_c;
					rd_q       <= hit_idx_c;
					free_q     <= free_c;
					free_idx_q <= free_idx_c;
					state_q    <= S_EXEC;
				end
				S_EXEC: begin
					unique case (item_q.op)
						OP_CONNECT: begin
							if (!hit_q && !free_q) begin
								fail_q  <= 1'b1;
								state_q <= S_EMIT_CODE;
							end else begin
								if (!hit_q) begin
									ent_vld_q[free_idx_q] <= 1'b1;
								end
								if (item_q.sess_ok) begin
									sess_vld_q[sidx] <= 1'b1;
								end
								if (item_q.sess_ok && held_ok) begin
									rd_q    <= sess_rd_q;
									tgt_q   <= conn_idx;
									after_q <= AFT_ENTRY;
									state_q <= S_DROP;
								end else begin
									rd_q    <= conn_idx;
									state_q <= S_EMIT;
								end
							end
						end
						OP_DISCONNECT: begin
							if (hit_q) begin
								if (item_q.sess_ok && sess_vld_q[sidx] && (sess_rd_q == rd_q)) begin
									sess_vld_q[sidx] <= 1'b0;
								end
								after_q <= AFT_ZERO;
								state_q <= S_DROP;
							end else begin
								fail_q  <= 1'b0;
								state_q <= S_EMIT_CODE;
							end
						end
						OP_LOOKUP: begin
							if (hit_q) begin
								state_q <= S_EMIT;
							end else begin
								fail_q  <= 1'b1;
								state_q <= S_EMIT_CODE;
							end
						end
						OP_DUMP: begin
							state_q <= S_DUMP_HDR;
						end
						OP_SESS_END: begin
							if (item_q.sess_ok && sess_vld_q[sidx]) begin
								sess_vld_q[sidx] <= 1'b0;
								if (ent_vld_q[sess_rd_q]) begin
									rd_q    <= sess_rd_q;
									after_q <= AFT_NONE;
									state_q <= S_DROP;
								end else begin
									state_q <= S_IDLE;
								end
							end else begin
								state_q <= S_IDLE;
							end
						end
						OP_TICK: begin
							now_q     <= now_inc;
							ent_vld_q <= ent_vld_q & ~del_c;
							del_q     <= del_c;
							swp_q     <= '0;
							state_q   <= (|del_c) ? S_SWP_RD : S_IDLE;
						end
						default: begin
							fail_q  <= 1'b1;
							state_q <= S_EMIT_CODE;
						end
					endcase
				end
				S_DROP: begin
					unique case (after_q)
						AFT_ENTRY: begin
							rd_q    <= tgt_q;
							state_q <= S_EMIT;
						end
						AFT_ZERO: begin
							fail_q  <= 1'b0;
							state_q <= S_EMIT_CODE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						out_q     <= '{1'b0, rd_rec.cnt, rd_rec.rate, rd_rec.key, 1'b1, 1'b1};
						state_q   <= S_IDLE;
					end
				end
				S_EMIT_CODE: begin
					if (out_free) begin
						out_q     <= '{fail_q, 16'd0, 16'd0, 32'd0, 1'b0, 1'b1};
						state_q   <= S_IDLE;
					end
				end
				S_DUMP_HDR: begin
					if (out_free) begin
						out_q     <= '{1'b0, 16'd0, 16'd0, 32'd0, 1'b0, ~|ent_vld_q};
						rd_q      <= '0;
						state_q   <= (|ent_vld_q) ? S_DUMP : S_IDLE;
					end
				end
				S_DUMP: begin
					if (!ent_vld_q[rd_q] || out_free) begin
						if (ent_vld_q[rd_q]) begin
							out_q     <= '{1'b0, rd_rec.cnt, rd_rec.rate, rd_rec.key, 1'b1,
							               ~above_c};
						end
						if (rd_q == EW'(TABLE_ENTRIES - 1)) begin
							state_q <= S_IDLE;
						end else begin
							rd_q <= rd_q + EW'(1);
						end
					end
				end
				S_SWP_RD: begin
					state_q <= S_SWP_CHK;
				end
				S_SWP_CHK: begin
					if (sess_vld_q[swp_q] && del_q[sess_rd_q]) begin
						sess_vld_q[swp_q] <= 1'b0;
					end
					if (swp_q == SW'(LOCAL_SESSIONS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						swp_q   <= swp_q + SW'(1);
						state_q <= S_SWP_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== verif/per_client_connection_rate_table_core_test.sv =====
// Self-checking test of the per-client connection rate table core.
// Drives request words and register writes, predicts every result word and
// compares it field by field. Depends on cprt_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module per_client_connection_rate_table_core_test;
	import cprt_pkg::*;

	localparam int NSLOT = TABLE_ENTRIES_DEF;
	localparam int NSESS = LOCAL_SESSIONS_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [KIND_W-1:0] KIND_BAD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_BAD7 = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0] client_key;
	logic [SESS_W-1:0] local_session;
	logic out_valid;
	logic out_ready;
	logic status;
	logic [CNT_W-1:0] conn_count;
	logic [CNT_W-1:0] conn_rate;
	logic [KEY_W-1:0] entry_key;
	logic entry_present;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	per_client_connection_rate_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.client_key(client_key), .local_session(local_session),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.conn_count(conn_count), .conn_rate(conn_rate), .entry_key(entry_key),
		.entry_present(entry_present), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted copy of the table, session bindings, clock and registers.
	logic             tbl_valid [NSLOT];
	logic [KEY_W-1:0] tbl_key [NSLOT];
	logic [CNT_W-1:0] tbl_count [NSLOT];
	logic [CNT_W-1:0] tbl_rate [NSLOT];
	logic [31:0]      tbl_win [NSLOT];
	logic [31:0]      tbl_idle [NSLOT];
	logic [4:0]       sess_slot [NSESS];
	logic [31:0]      ticks;
	logic [CFG_W-1:0] window_len;
	logic [CFG_W-1:0] idle_limit;

	res_t pending_words[$];
	int   errors;
	int   words_seen;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic [KEY_W-1:0] key_pool [8];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("Mismatch in %s at word %0d: got %0h, expected %0h",
			what, words_seen, got, want);
	endtask

	// Result checker: every word accepted on the output is popped against the
	// oldest prediction.
	always @(posedge clk) begin
		res_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", {31'b0, last}, 32'b0);
			end else begin
				exp_w = pending_words.pop_front();
				if (status !== exp_w.status)
					report_mismatch("status", 32'(status), 32'(exp_w.status));
				if (conn_count !== exp_w.conn_count)
					report_mismatch("conn_count", 32'(conn_count), 32'(exp_w.conn_count));
				if (conn_rate !== exp_w.conn_rate)
					report_mismatch("conn_rate", 32'(conn_rate), 32'(exp_w.conn_rate));
				if (entry_key !== exp_w.entry_key)
					report_mismatch("entry_key", entry_key, exp_w.entry_key);
				if (entry_present !== exp_w.entry_present)
					report_mismatch("entry_present", 32'(entry_present),
						32'(exp_w.entry_present));
				if (last !== exp_w.last)
					report_mismatch("last", 32'(last), 32'(exp_w.last));
			end
			words_seen++;
		end
	end

	// The receiver stalls at random on each falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic res_t make_word(logic st, logic [CNT_W-1:0] cnt,
			logic [CNT_W-1:0] rt, logic [KEY_W-1:0] k, logic pres, logic lst);
		res_t w;
		w.status = st;
		w.conn_count = cnt;
		w.conn_rate = rt;
		w.entry_key = k;
		w.entry_present = pres;
		w.last = lst;
		return w;
	endfunction

	function automatic int slot_of(logic [KEY_W-1:0] k);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void release_one(int i);
		if (tbl_count[i] != 0) begin
			tbl_count[i]--;
			if (tbl_count[i] == 0)
				tbl_idle[i] = ticks;
		end
	endfunction

	function automatic void release_held(int s);
		int h;
		h = sess_slot[s];
		if (h != 0 && tbl_valid[h-1])
			release_one(h - 1);
	endfunction

	// Applies one request word to the predicted state and queues its results.
	function automatic void predict_request(logic [KIND_W-1:0] k,
			logic [KEY_W-1:0] key, logic [SESS_W-1:0] s);
		int i;
		case (k)
			KIND_CONNECT: begin
				i = slot_of(key);
				if (i < 0) begin
					for (i = 0; i < NSLOT; i++)
						if (!tbl_valid[i])
							break;
					if (i >= NSLOT) begin
						pending_words.push_back(make_word(1, 0, 0, 0, 0, 1));
						return;
					end
					tbl_valid[i] = 1;
					tbl_key[i] = key;
					tbl_count[i] = 1;
					tbl_rate[i] = 1;
					tbl_win[i] = ticks;
					tbl_idle[i] = 0;
				end else begin
					if (ticks - tbl_win[i] > {16'b0, window_len}) begin
						tbl_rate[i] = 1;
						tbl_win[i] = ticks;
					end else if (tbl_rate[i] != CNT_MAX) begin
						tbl_rate[i]++;
					end
					if (tbl_count[i] != CNT_MAX)
						tbl_count[i]++;
				end
				// A new connect releases whatever key the session held, even the same one.
				release_held(s);
				sess_slot[s] = 5'(i + 1);
				pending_words.push_back(make_word(0, tbl_count[i], tbl_rate[i], key, 1, 1));
			end
			KIND_DISCONNECT: begin
				i = slot_of(key);
				if (i >= 0) begin
					release_one(i);
					if (sess_slot[s] == i + 1)
						sess_slot[s] = 0;
				end
				pending_words.push_back(make_word(0, 0, 0, 0, 0, 1));
			end
			KIND_LOOKUP: begin
				i = slot_of(key);
				if (i < 0)
					pending_words.push_back(make_word(1, 0, 0, 0, 0, 1));
				else
					pending_words.push_back(make_word(0, tbl_count[i], tbl_rate[i], key, 1, 1));
			end
			KIND_DUMP: begin
				pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
				for (i = 0; i < NSLOT; i++)
					if (tbl_valid[i])
						pending_words.push_back(make_word(0, tbl_count[i], tbl_rate[i],
							tbl_key[i], 1, 0));
				pending_words[$].last = 1;
			end
			KIND_SESS_END: begin
				release_held(s);
				sess_slot[s] = 0;
			end
			KIND_TICK: begin
				ticks++;
				for (i = 0; i < NSLOT; i++)
					if (tbl_valid[i] && tbl_count[i] == 0 &&
						ticks - tbl_idle[i] >= {16'b0, idle_limit}) begin
						tbl_valid[i] = 0;
						tbl_key[i] = 0;
						tbl_rate[i] = 0;
						tbl_win[i] = 0;
						tbl_idle[i] = 0;
						for (int j = 0; j < NSESS; j++)
							if (sess_slot[j] == i + 1)
								sess_slot[j] = 0;
					end
			end
			default: begin
				pending_words.push_back(make_word(1, 0, 0, 0, 0, 1));
			end
		endcase
	endfunction

	// Sends one request word, holding it until accepted, then predicts it.
	// The word stays on the port after acceptance; the next call or a drain
	// replaces or withdraws it, so back-to-back words leave no gap.
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] key,
			input logic [SESS_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		client_key <= key;
		local_session <= s;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(k, key, s);
		@(negedge clk);
	endtask

	// Waits for every predicted word, then lets trailing work finish.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (1000) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_SAMPLE_PERIOD)
			window_len = val;
		else
			idle_limit = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic tick_n(input int n);
		repeat (n) send_request(KIND_TICK, $urandom, SESS_W'($urandom));
	endtask

	// Directed: every request code, field extremes, full table, unknown codes.
	task automatic test_directed;
		send_request(KIND_LOOKUP, 32'h0, 0);
		send_request(KIND_DUMP, 0, 0);
		send_request(KIND_CONNECT, 32'h0, 0);
		send_request(KIND_CONNECT, 32'hFFFF_FFFF, 6'd63);
		send_request(KIND_CONNECT, 32'h0, 0);
		send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 1);
		send_request(KIND_DISCONNECT, 32'hFFFF_FFFF, 6'd63);
		send_request(KIND_DISCONNECT, 32'h1234_5678, 5);
		send_request(KIND_SESS_END, 0, 0);
		send_request(KIND_SESS_END, 0, 6'd40);
		send_request(KIND_BAD6, 32'hAAAA_5555, 6'h2A);
		send_request(KIND_BAD7, 32'h5555_AAAA, 6'h15);
		for (int i = 0; i < NSLOT + 1; i++)
			send_request(KIND_CONNECT, 32'h100 + i, SESS_W'(i));
		send_request(KIND_DUMP, 0, 0);
		tick_n(3);
	endtask

	// Zero and maximum windows and purge delays: with zero, rates restart and idle entries vanish.
	task automatic test_register_extremes;
		write_register(REG_SAMPLE_PERIOD, 16'd0);
		write_register(REG_PURGE_DELAY, 16'd0);
		send_request(KIND_CONNECT, 32'h100, 7);
		send_request(KIND_CONNECT, 32'h100, 8);
		tick_n(1);
		send_request(KIND_CONNECT, 32'h100, 9);
		for (int s = 0; s < NSESS; s++)
			send_request(KIND_SESS_END, 0, SESS_W'(s));
		for (int i = 0; i < NSLOT + 1; i++)
			send_request(KIND_DISCONNECT, 32'h100 + i, 0);
		tick_n(2);
		send_request(KIND_DUMP, 0, 0);
		write_register(REG_SAMPLE_PERIOD, 16'hFFFF);
		write_register(REG_PURGE_DELAY, 16'hFFFF);
		send_request(KIND_CONNECT, 32'hFFFF_FFFF, 3);
		send_request(KIND_CONNECT, 32'hFFFF_FFFF, 3);
		send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 3);
	endtask

	function automatic logic [KIND_W-1:0] pick_kind;
		int r;
		r = $urandom_range(99);
		if (r < 40) return KIND_CONNECT;
		if (r < 55) return KIND_DISCONNECT;
		if (r < 65) return KIND_LOOKUP;
		if (r < 70) return KIND_DUMP;
		if (r < 80) return KIND_SESS_END;
		if (r < 98) return KIND_TICK;
		return $urandom_range(1) ? KIND_BAD6 : KIND_BAD7;
	endfunction

	// Random traffic over a small key pool so entries are reused and purged.
	task automatic test_random_phase(input int n, input int idle, input int stall,
			input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] purge);
		logic [KEY_W-1:0] key;
		write_register(REG_SAMPLE_PERIOD, win);
		write_register(REG_PURGE_DELAY, purge);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom;
		for (int i = 0; i < n; i++) begin
			key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(7)];
			send_request(pick_kind(), key, SESS_W'(($urandom_range(15) == 0) ?
				$urandom : $urandom_range(7)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_CONNECT;
		client_key = '0;
		local_session = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SAMPLE_PERIOD;
		cfg_data = '0;
		errors = 0;
		words_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_valid[i] = 0; tbl_key[i] = 0; tbl_count[i] = 0;
			tbl_rate[i] = 0; tbl_win[i] = 0; tbl_idle[i] = 0;
		end
		for (int s = 0; s < NSESS; s++)
			sess_slot[s] = 0;
		ticks = 0;
		window_len = SAMPLE_PERIOD_RST;
		idle_limit = PURGE_DELAY_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_register_extremes();
		test_random_phase(40, 0, 0, 16'd3, 16'd4);
		test_random_phase(40, 49, 0, 16'd1, 16'd2);
		// The sender holds off here until every result word has come back.
		drain();
		test_random_phase(40, 0, 49, 16'd5, 16'd1);
		test_random_phase(40, 20, 20, SAMPLE_PERIOD_RST, 16'd8);
		drain();

		$display("Covered all request codes, full table, register extremes and");
		$display("%0d result words under four idle and stall mixes.", words_seen);
		if (errors == 0 && pending_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== per_client_connection_rate_table_core.f =====
design/cprt_pkg.sv
design/cprt_front.sv
design/cprt_engine.sv
design/per_client_connection_rate_table_core.sv
verif/per_client_connection_rate_table_core_test.sv
